>>> design/plwq_pkg.sv
package plwq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_WIDTH    = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_W    = 3;

    typedef logic [ID_WIDTH-1:0] id_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_HANDED    = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // Request kinds
    typedef enum logic {
        KIND_ACQUIRE = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_GRANT,
        OP_INSERT,
        OP_POP,
        OP_FREE
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        op_t     op;
        logic    load_result;
        status_t status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  held;
        logic  owner_match;
        logic  empty;
        logic  full;
    } stat_t;

endpackage

>>> design/plwq_req_if.sv
interface plwq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [plwq_pkg::ID_WIDTH-1:0] requester_id;

    modport source (output valid, output kind, output requester_id, input ready);
    modport sink   (input valid, input kind, input requester_id, output ready);
endinterface

>>> design/plwq_rsp_if.sv
interface plwq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [plwq_pkg::STATUS_W-1:0] status;
    logic [plwq_pkg::ID_WIDTH-1:0] owner_id;
    logic [plwq_pkg::ID_WIDTH-1:0] woken_id;

    modport source (output valid, output status, output owner_id, output woken_id,
                    input ready);
    modport sink   (input valid, input status, input owner_id, input woken_id,
                    output ready);
endinterface

>>> design/plwq_datapath.sv
module plwq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_kind,
    input  logic [plwq_pkg::ID_WIDTH-1:0] req_id,
    input  plwq_pkg::cmd_t                cmd,
    output plwq_pkg::stat_t               stat,
    output logic [plwq_pkg::STATUS_W-1:0] status,
    output logic [plwq_pkg::ID_WIDTH-1:0] owner_id,
    output logic [plwq_pkg::ID_WIDTH-1:0] woken_id
);
    import plwq_pkg::*;

    kind_t   kind_reg;
    id_t     id_reg;
    logic    held_reg;
    logic    held_next;
    id_t     owner_reg;
    id_t     owner_next;
    count_t  count_reg;
    count_t  count_next;
    id_t     waiters_reg  [QUEUE_DEPTH];
    id_t     waiters_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] stay;
    status_t status_reg;
    id_t     owner_out_reg;
    id_t     woken_reg;

    // Hold the captured request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(req_kind);
            id_reg   <= req_id;
        end
    end

    // Report the lock state against the captured request
    assign stat.kind        = kind_reg;
    assign stat.held        = held_reg;
    assign stat.owner_match = (owner_reg == id_reg);
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == COUNT_W'(QUEUE_DEPTH));

    // Mark cells that keep their entry on insert (valid and not below the new id)
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            stay[i] = (COUNT_W'(i) < count_reg) && (waiters_reg[i] >= id_reg);
        end
    end

    // Shift chain: insert shifts the tail down, pop shifts everything up
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            waiters_next[i] = waiters_reg[i];
            case (cmd.op)
                OP_INSERT:
                begin
                    if (!stay[i])
                    begin
                        if (i == 0)
                        begin
                            waiters_next[i] = id_reg;
                        end
                        else if (stay[i-1])
                        begin
                            waiters_next[i] = id_reg;
                        end
                        else
                        begin
                            waiters_next[i] = waiters_reg[i-1];
                        end
                    end
                end
                OP_POP:
                begin
                    if (i < QUEUE_DEPTH - 1)
                    begin
                        waiters_next[i] = waiters_reg[i+1];
                    end
                end
                default:
                begin
                    waiters_next[i] = waiters_reg[i];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            waiters_reg[i] <= waiters_next[i];
        end
    end

    // Update owner and fill count
    always_comb
    begin
        held_next  = held_reg;
        owner_next = owner_reg;
        count_next = count_reg;
        case (cmd.op)
            OP_GRANT:
            begin
                held_next  = 1'b1;
                owner_next = id_reg;
            end
            OP_INSERT:
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            OP_POP:
            begin
                owner_next = waiters_reg[0];
                count_next = count_reg - COUNT_W'(1);
            end
            OP_FREE:
            begin
                held_next  = 1'b0;
                owner_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            owner_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            owner_reg <= owner_next;
            count_reg <= count_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status_reg    <= cmd.status;
            owner_out_reg <= held_next ? owner_next : '0;
            woken_reg     <= (cmd.op == OP_POP) ? waiters_reg[0] : '0;
        end
    end

    assign status   = status_reg;
    assign owner_id = owner_out_reg;
    assign woken_id = woken_reg;

endmodule

>>> design/plwq_ctrl.sv
module plwq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  plwq_pkg::stat_t stat,
    output plwq_pkg::cmd_t  cmd
);
    import plwq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   req_ready_reg;
    logic   rsp_valid_reg;

    // Advance state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_ready_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready_reg)
                    begin
                        state_reg     <= S_EXEC;
                        req_ready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    state_reg     <= S_OUT;
                    rsp_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (rsp_ready)
                    begin
                        state_reg     <= S_IDLE;
                        rsp_valid_reg <= 1'b0;
                        req_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    req_ready_reg <= 1'b1;
                    rsp_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign req_ready = req_ready_reg;
    assign rsp_valid = rsp_valid_reg;

    // Decide the operation for the captured request
    always_comb
    begin
        cmd.capture     = (state_reg == S_IDLE) && req_valid && req_ready_reg;
        cmd.op          = OP_NONE;
        cmd.load_result = 1'b0;
        cmd.status      = ST_GRANTED;
        if (state_reg == S_EXEC)
        begin
            cmd.load_result = 1'b1;
            case (stat.kind)
                KIND_ACQUIRE:
                begin
                    if (!stat.held)
                    begin
                        cmd.op     = OP_GRANT;
                        cmd.status = ST_GRANTED;
                    end
                    else if (stat.full)
                    begin
                        cmd.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = OP_INSERT;
                        cmd.status = ST_QUEUED;
                    end
                end
                KIND_RELEASE:
                begin
                    if (!stat.held || !stat.owner_match)
                    begin
                        cmd.status = ST_NOT_OWNER;
                    end
                    else if (stat.empty)
                    begin
                        cmd.op     = OP_FREE;
                        cmd.status = ST_FREED;
                    end
                    else
                    begin
                        cmd.op     = OP_POP;
                        cmd.status = ST_HANDED;
                    end
                end
                default:
                begin
                    cmd.status = ST_NOT_OWNER;
                end
            endcase
        end
    end

endmodule

>>> design/priority_lock_wait_queue_top.sv
// Single lock with a priority wait queue. Each request item is an acquire or a
// release by a requester id, which is also its priority (higher is served first).
// An acquire of a free lock is granted; an acquire of a held lock is placed in a
// 64-entry wait queue in descending id order behind equal ids, or flagged as
// queue full. A release by the owner hands the lock to the queue head (reported
// as woken_id) or frees it; a release by anyone else is refused. Each request
// gives exactly one response. The queue is a shifting sorted register chain; the
// controller takes one item at a time through capture, execute and response, and
// accepts no new request until the response side has taken the last response.
module priority_lock_wait_queue_top (
    input  logic       clk,
    input  logic       rst_n,
    plwq_req_if.sink   req,
    plwq_rsp_if.source rsp
);
    import plwq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    plwq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    plwq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_kind (req.kind),
        .req_id   (req.requester_id),
        .cmd      (cmd),
        .stat     (stat),
        .status   (rsp.status),
        .owner_id (rsp.owner_id),
        .woken_id (rsp.woken_id)
    );

endmodule
